>>> sv/udf_pkg.sv
// ----------------------------------------------------------------------------
// udf_pkg
// Types, constants and helpers shared by the decimal field formatter.
// ----------------------------------------------------------------------------
package udf_pkg;

    localparam int VALUE_W           = 32;
    localparam int LEN_W             = 7;
    localparam int BCD_DIGITS        = 10;
    localparam int BCD_W             = 4 * BCD_DIGITS;
    localparam int CONV_STEPS        = VALUE_W;
    localparam int DEFAULT_MAX_FIELD = 63;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    localparam logic [1:0] MODE_RIGHT = 2'd0;
    localparam logic [1:0] MODE_LEFT  = 2'd1;
    localparam logic [1:0] MODE_ZERO  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef logic [LEN_W-1:0] t_len;

    // field layout: [0,b1) pad, [b1,b2) zeros, [b2,b3) digits, [b3,n) right pad
    typedef struct packed {
        logic [7:0] pad_char;
        t_len       b1;
        t_len       b2;
        t_len       b3;
        t_len       n;
    } t_plan;

    function automatic logic [3:0] digit_at(input logic [BCD_W-1:0] bcd,
                                            input logic [3:0]       idx);
        logic [3:0] d;
        d = '0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (idx == 4'(i)) begin
                d = bcd[i*4 +: 4];
            end
        end
        return d;
    endfunction

endpackage

>>> sv/udf_if.sv
// ----------------------------------------------------------------------------
// udf_if
// Valid/ready channels for the formatter: request in, characters out.
// ----------------------------------------------------------------------------
interface udf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [5:0]  field_width;
    logic [5:0]  precision;
    logic        has_precision;
    logic [1:0]  align_mode;

    modport source (output valid, value, field_width, precision, has_precision,
                    align_mode, input ready);
    modport sink   (input valid, value, field_width, precision, has_precision,
                    align_mode, output ready);
endinterface

interface udf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_out;
    logic        last_char;
    logic [31:0] total_printed;

    modport source (output valid, char_out, last_char, total_printed, input ready);
    modport sink   (input valid, char_out, last_char, total_printed, output ready);
endinterface

>>> sv/unsigned_decimal_field_formatter.sv
// A request runs through the 32-step shift-and-add-3 conversion, S_PREP (digit count) and
// S_PLAN (field layout), then goes out one character per cycle from the output register
// while the receiver is ready; no new request is taken until the emitter has finished.
// A field with no characters emits nothing.
// Reset (synchronous, active low) clears the running character count and goes idle.
// ----------------------------------------------------------------------------
// unsigned_decimal_field_formatter
// Prints a 32-bit unsigned value in decimal inside a padded field.
// ----------------------------------------------------------------------------
module unsigned_decimal_field_formatter #(
    parameter int MAX_FIELD = udf_pkg::DEFAULT_MAX_FIELD
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    udf_in_if.sink     i_in,
    udf_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_PLAN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam udf_pkg::t_len MAX_LEN = udf_pkg::t_len'(MAX_FIELD);

    logic [2:0]                  r_state;
    udf_pkg::t_len               r_width;
    udf_pkg::t_len               r_prec;
    logic                        r_hasp;
    logic [1:0]                  r_mode;
    udf_pkg::t_len               r_ndig;
    udf_pkg::t_plan              r_plan;
    logic                        n_accept;
    logic                        bcd_done;
    logic [udf_pkg::BCD_W-1:0]   bcd;
    logic                        emit_busy;
    logic                        n_emit_start;
    udf_pkg::t_len               n_width;
    udf_pkg::t_len               n_prec;
    udf_pkg::t_len               n_ndig;
    udf_pkg::t_len               n_lz;
    udf_pkg::t_len               n_body;
    udf_pkg::t_len               n_pad;
    udf_pkg::t_len               n_lead;
    udf_pkg::t_plan              n_plan;

    assign i_in.ready = (r_state == S_IDLE);
    assign n_accept   = i_in.valid && i_in.ready;

    assign n_width = ({1'b0, i_in.field_width} > MAX_LEN) ? MAX_LEN : {1'b0, i_in.field_width};
    assign n_prec  = ({1'b0, i_in.precision} > MAX_LEN) ? MAX_LEN : {1'b0, i_in.precision};

    // digit count: highest nonzero BCD digit, at least one, or none for a zero value with explicit zero precision
    always_comb begin
        n_ndig = udf_pkg::t_len'(1);
        for (int i = 1; i < udf_pkg::BCD_DIGITS; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                n_ndig = udf_pkg::t_len'(i + 1);
            end
        end
        if (r_hasp && r_prec == '0 && bcd == '0) begin
            n_ndig = '0;
        end
    end

    always_comb begin
        n_lz   = (r_hasp && r_prec > r_ndig) ? r_prec - r_ndig : '0;
        n_body = r_ndig + n_lz;
        n_pad  = (r_width > n_body) ? r_width - n_body : '0;
        n_lead = (r_mode == udf_pkg::MODE_LEFT) ? '0 : n_pad;
        n_plan.pad_char = (r_mode == udf_pkg::MODE_ZERO && r_ndig != '0)
                          ? udf_pkg::ASCII_ZERO : udf_pkg::ASCII_SPACE;
        n_plan.b1 = n_lead;
        n_plan.b2 = n_lead + n_lz;
        n_plan.b3 = n_lead + n_lz + r_ndig;
        n_plan.n  = n_body + n_pad;
    end

    assign n_emit_start = (r_state == S_PLAN) && (n_plan.n != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (bcd_done) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_PLAN;
                end
                S_PLAN: begin
                    r_state <= n_emit_start ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (!emit_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_width <= n_width;
            r_prec  <= n_prec;
            r_hasp  <= i_in.has_precision;
            r_mode  <= (i_in.align_mode == udf_pkg::MODE_SPARE) ? udf_pkg::MODE_RIGHT
                                                                : i_in.align_mode;
        end
        if (r_state == S_PREP) begin
            r_ndig <= n_ndig;
        end
        if (r_state == S_PLAN) begin
            r_plan <= n_plan;
        end
    end

    udf_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_accept),
        .i_value (i_in.value),
        .o_bcd   (bcd),
        .o_done  (bcd_done)
    );

    udf_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_emit_start),
        .i_plan  (n_emit_start ? n_plan : r_plan),
        .i_bcd   (bcd),
        .o_busy  (emit_busy),
        .o_out   (o_out)
    );

    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !emit_busy) else $error("ready while emitting");
    a_field_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PLAN |-> n_plan.n <= MAX_LEN) else $error("field too long");
    a_emit_after_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_emit_start |=> emit_busy && r_state == S_EMIT) else $error("emit not started");

endmodule

>>> sv/udf_bcd.sv
// ----------------------------------------------------------------------------
// udf_bcd
// Shift-and-add-3 binary to BCD converter, one bit per cycle.
// ----------------------------------------------------------------------------
module udf_bcd (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [udf_pkg::VALUE_W-1:0]  i_value,
    output logic [udf_pkg::BCD_W-1:0]    o_bcd,
    output logic                         o_done
);

    localparam int CNT_W = $clog2(udf_pkg::CONV_STEPS);

    logic                        r_busy;
    logic [CNT_W-1:0]            r_cnt;
    logic [udf_pkg::VALUE_W-1:0] r_bin;
    logic [udf_pkg::BCD_W-1:0]   r_bcd;
    logic                        r_done;
    logic [udf_pkg::BCD_W-1:0]   n_adj;

    always_comb begin
        for (int i = 0; i < udf_pkg::BCD_DIGITS; i++) begin
            n_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? r_bcd[i*4 +: 4] + 4'd3
                                                        : r_bcd[i*4 +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_bin  <= i_value;
                r_bcd  <= '0;
            end else if (r_busy) begin
                {r_bcd, r_bin} <= {n_adj[udf_pkg::BCD_W-2:0], r_bin, 1'b0};
                r_cnt          <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(udf_pkg::CONV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_bcd  = r_bcd;
    assign o_done = r_done;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without conversion");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && r_cnt == '0) else $error("start not taken");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("busy after done");

endmodule

>>> sv/udf_emit.sv
// ----------------------------------------------------------------------------
// udf_emit
// Character sequencer: walks the field layout and fills the output register.
// ----------------------------------------------------------------------------
module udf_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  udf_pkg::t_plan             i_plan,
    input  logic [udf_pkg::BCD_W-1:0]  i_bcd,
    output logic                       o_busy,
    udf_out_if.source                  o_out
);

    logic              r_active;
    udf_pkg::t_len     r_pos;
    logic [31:0]       r_count;
    logic              r_ovalid;
    logic [7:0]        r_char;
    logic              r_last;
    logic [31:0]       r_total;
    logic              n_adv;
    logic              n_last;
    logic [7:0]        n_char;
    udf_pkg::t_len     n_di;

    assign n_adv  = r_active && (!r_ovalid || o_out.ready);
    assign n_last = (r_pos + 1'b1) == i_plan.n;
    assign n_di   = i_plan.b3 - r_pos - 1'b1;

    always_comb begin
        if (r_pos < i_plan.b1) begin
            n_char = i_plan.pad_char;
        end else if (r_pos < i_plan.b2) begin
            n_char = udf_pkg::ASCII_ZERO;
        end else if (r_pos < i_plan.b3) begin
            n_char = udf_pkg::ASCII_ZERO + {4'd0, udf_pkg::digit_at(i_bcd, n_di[3:0])};
        end else begin
            n_char = udf_pkg::ASCII_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_start) begin
                r_active <= 1'b1;
                r_pos    <= '0;
            end else if (n_adv) begin
                r_pos   <= r_pos + 1'b1;
                r_count <= r_count + 1'b1;
                if (n_last) begin
                    r_active <= 1'b0;
                end
            end
            if (n_adv) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_char  <= n_char;
            r_last  <= n_last;
            r_total <= r_count + 32'd1;
        end
    end

    assign o_busy              = r_active;
    assign o_out.valid         = r_ovalid;
    assign o_out.char_out      = r_char;
    assign o_out.last_char     = r_last;
    assign o_out.total_printed = r_total;

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_adv |=> r_count == $past(r_count) + 32'd1) else $error("count slip");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_pos < i_plan.n) else $error("position past field end");
    a_digit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && r_pos >= i_plan.b2 && r_pos < i_plan.b3
        |-> n_di < udf_pkg::t_len'(udf_pkg::BCD_DIGITS)) else $error("bad digit index");

endmodule

>>> tb/tb_unsigned_decimal_field_formatter.sv
// ----------------------------------------------------------------------------
// tb_unsigned_decimal_field_formatter
// Drives formatting requests through the input channel and checks every character,
// end-of-field flag and running count against typed text or a local predictor.
// A table of directed requests comes first, then random requests under
// several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb_unsigned_decimal_field_formatter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 88;   // per idling phase
    localparam int FIELD_MAX    = udf_pkg::DEFAULT_MAX_FIELD;
    localparam int RADIX        = 10;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  field_width;
        logic [5:0]  precision;
        logic        has_precision;
        logic [1:0]  align_mode;
    } t_request;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic [31:0] total;
    } t_char_expect;

    typedef struct {
        t_request req;
        bit       typed;
        string    text;
    } t_dir_row;

    typedef logic [7:0] t_text [$];

    logic i_clk = 1'b0;
    logic i_rst_n;

    udf_in_if  in_ch ();
    udf_out_if out_ch ();

    unsigned_decimal_field_formatter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_char_expect expected_chars [$];
    t_dir_row     directed_rows [$];
    logic [31:0]  chars_emitted = '0;
    int           src_idle_pct  = 0;
    int           snk_stall_pct = 0;
    int           mismatches    = 0;
    int           chars_checked = 0;
    int           n_requests    = 0;
    int           n_empty       = 0;
    int           longest_field = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
        end
        mismatches++;
    endtask

    // Field layout: left pad, precision zeros, digits, right pad.
    function automatic void render_field(input t_request r, output t_text text);
        logic [7:0]  digs [10];
        logic [31:0] v;
        int unsigned ndig, width, prec, zeros, pad;
        logic [1:0]  mode;
        text = {};
        v    = r.value;
        ndig = 0;
        do begin
            digs[ndig] = udf_pkg::ASCII_ZERO + 8'(v % RADIX);
            ndig++;
            v = v / RADIX;
        end while (v != 0);
        width = (r.field_width > FIELD_MAX) ? FIELD_MAX : r.field_width;
        prec  = (r.precision > FIELD_MAX) ? FIELD_MAX : r.precision;
        mode  = (r.align_mode == udf_pkg::MODE_SPARE) ? udf_pkg::MODE_RIGHT : r.align_mode;
        // explicit zero precision on a zero value prints no digits
        if (r.has_precision && prec == 0 && r.value == 0) begin
            ndig = 0;
        end
        zeros = (r.has_precision && prec > ndig) ? prec - ndig : 0;
        pad   = (width > ndig + zeros) ? width - (ndig + zeros) : 0;
        if (mode != udf_pkg::MODE_LEFT) begin
            // zero padding falls back to spaces when there are no digits
            repeat (pad) text.push_back((mode == udf_pkg::MODE_ZERO && ndig != 0) ?
                                        udf_pkg::ASCII_ZERO : udf_pkg::ASCII_SPACE);
        end
        repeat (zeros) text.push_back(udf_pkg::ASCII_ZERO);
        for (int i = ndig; i > 0; i--) begin
            text.push_back(digs[i-1]);
        end
        if (mode == udf_pkg::MODE_LEFT) begin
            repeat (pad) text.push_back(udf_pkg::ASCII_SPACE);
        end
    endfunction

    function automatic void queue_field(input t_text text);
        t_char_expect e;
        n_requests++;
        if (text.size() == 0) begin
            n_empty++;
        end
        if (text.size() > longest_field) begin
            longest_field = text.size();
        end
        for (int i = 0; i < text.size(); i++) begin
            chars_emitted++;
            e.ch    = text[i];
            e.last  = (i == text.size() - 1);
            e.total = chars_emitted;
            expected_chars.push_back(e);
        end
    endfunction

    function automatic void add_row(input logic [31:0] value, input int width,
                                    input int prec, input bit has_prec,
                                    input logic [1:0] mode, input bit typed,
                                    input string text);
        t_dir_row row;
        row.req.value         = value;
        row.req.field_width   = 6'(width);
        row.req.precision     = 6'(prec);
        row.req.has_precision = has_prec;
        row.req.align_mode    = mode;
        row.typed             = typed;
        row.text              = text;
        directed_rows.push_back(row);
    endfunction

    function automatic t_request random_request();
        t_request    r;
        logic [31:0] p;
        int          k;
        r.field_width   = ($urandom_range(9) < 8) ? 6'($urandom_range(12))
                                                  : 6'($urandom_range(63));
        r.precision     = ($urandom_range(9) < 7) ? 6'($urandom_range(12))
                                                  : 6'($urandom_range(63));
        r.has_precision = 1'($urandom_range(1));
        r.align_mode    = 2'($urandom_range(3));
        case ($urandom_range(5))
            0: r.value = '0;
            1: r.value = $urandom_range(9);
            2: begin
                // around a power of ten, where the digit count changes
                p = 1;
                k = $urandom_range(1, 9);
                repeat (k) p = p * RADIX;
                r.value = p - $urandom_range(1);
            end
            3: r.value = $urandom_range(99999);
            default: r.value = $urandom;
        endcase
        if ($urandom_range(19) == 0) begin
            r.value         = '0;
            r.has_precision = 1'b1;
            r.precision     = '0;
        end
        return r;
    endfunction

    task automatic send_request(input t_request r, input bit typed, input string text);
        t_text chars;
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.value         <= r.value;
        in_ch.field_width   <= r.field_width;
        in_ch.precision     <= r.precision;
        in_ch.has_precision <= r.has_precision;
        in_ch.align_mode    <= r.align_mode;
        do @(posedge i_clk); while (!in_ch.ready);
        if (typed) begin
            chars = {};
            for (int i = 0; i < text.len(); i++) begin
                chars.push_back(text[i]);
            end
        end else begin
            render_field(r, chars);
        end
        queue_field(chars);
    endtask

    // Output side: check accepted characters, then pick next ready.
    always @(posedge i_clk) begin
        t_char_expect e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected character", 32'(out_ch.char_out), '0);
            end else begin
                e = expected_chars.pop_front();
                if (out_ch.char_out !== e.ch) begin
                    report_mismatch("char_out", 32'(out_ch.char_out), 32'(e.ch));
                end
                if (out_ch.last_char !== e.last) begin
                    report_mismatch("last_char", 32'(out_ch.last_char), 32'(e.last));
                end
                if (out_ch.total_printed !== e.total) begin
                    report_mismatch("total_printed", out_ch.total_printed, e.total);
                end
                chars_checked++;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d characters still expected", expected_chars.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.value         <= '0;
        in_ch.field_width   <= '0;
        in_ch.precision     <= '0;
        in_ch.has_precision <= 1'b0;
        in_ch.align_mode    <= udf_pkg::MODE_RIGHT;

        add_row(32'd0,          0,  0,  0, udf_pkg::MODE_RIGHT, 1, "0");
        add_row(32'hFFFF_FFFF,  0,  0,  0, udf_pkg::MODE_RIGHT, 1, "4294967295");
        add_row(32'd0,          0,  0,  1, udf_pkg::MODE_RIGHT, 1, "");
        add_row(32'd0,          5,  0,  1, udf_pkg::MODE_RIGHT, 1, "     ");
        add_row(32'd0,          5,  0,  1, udf_pkg::MODE_ZERO,  1, "     ");
        add_row(32'd0,          5,  0,  1, udf_pkg::MODE_LEFT,  1, "     ");
        add_row(32'd42,         5,  0,  0, udf_pkg::MODE_RIGHT, 1, "   42");
        add_row(32'd42,         5,  0,  0, udf_pkg::MODE_LEFT,  1, "42   ");
        add_row(32'd42,         5,  0,  0, udf_pkg::MODE_ZERO,  1, "00042");
        add_row(32'd42,         5,  0,  0, udf_pkg::MODE_SPARE, 1, "   42");
        add_row(32'd42,         0,  4,  1, udf_pkg::MODE_RIGHT, 1, "0042");
        add_row(32'd42,         0,  4,  0, udf_pkg::MODE_RIGHT, 1, "42");
        add_row(32'd42,         8,  4,  1, udf_pkg::MODE_ZERO,  0, "");
        add_row(32'd42,         8,  4,  1, udf_pkg::MODE_LEFT,  1, "0042    ");
        add_row(32'hFFFF_FFFF, 63, 63,  1, udf_pkg::MODE_RIGHT, 0, "");
        add_row(32'hFFFF_FFFF, 63,  0,  0, udf_pkg::MODE_LEFT,  0, "");
        add_row(32'hFFFF_FFFF, 63,  0,  0, udf_pkg::MODE_ZERO,  0, "");
        add_row(32'd0,         63, 63,  1, udf_pkg::MODE_ZERO,  0, "");
        add_row(32'd0,         63,  0,  1, udf_pkg::MODE_ZERO,  0, "");
        add_row(32'd1000000000, 10, 10, 1, udf_pkg::MODE_LEFT,  1, "1000000000");
        add_row(32'd9,          1,  1,  1, udf_pkg::MODE_RIGHT, 1, "9");
        add_row(32'd7,          0, 63,  1, udf_pkg::MODE_LEFT,  0, "");
        add_row(32'd123456789,  3,  2,  1, udf_pkg::MODE_RIGHT, 1, "123456789");
        add_row(32'd0,          3,  0,  0, udf_pkg::MODE_ZERO,  1, "000");
        add_row(32'd0,          0,  1,  1, udf_pkg::MODE_RIGHT, 1, "0");

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].text);
        end

        // idling phases: none, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
                default: begin src_idle_pct = 37; snk_stall_pct = 37; end
            endcase
            repeat (RANDOM_ITEMS) send_request(random_request(), 1'b0, "");
        end
        in_ch.valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d empty fields, longest %0d chars), %0d chars checked",
                 n_requests, n_empty, longest_field, chars_checked);
        $display("idling: none, sender gaps, receiver stalls, both; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/udf_pkg.sv
sv/udf_if.sv
sv/udf_bcd.sv
sv/udf_emit.sv
sv/unsigned_decimal_field_formatter.sv
tb/tb_unsigned_decimal_field_formatter.sv
